/* design/acfp_pkg.sv */
// types, constants and codes shared by the ascii coordinate frame parser
// no dependencies
package acfp_pkg;

  // frame layout
  localparam int unsigned COORD_LEN   = 12;
  localparam int unsigned CMD_LEN     = 4;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [3:0] POS_FIELD1_END = 4'd3;
  localparam logic [3:0] POS_MARK_B     = 4'd4;
  localparam logic [3:0] POS_FIELD2_END = 4'd7;
  localparam logic [3:0] POS_MARK_C     = 4'd8;
  localparam logic [3:0] POS_COORD_LAST = 4'(COORD_LEN - 1);
  localparam logic [3:0] POS_CMD_LAST   = 4'(CMD_LEN - 1);
  localparam logic [3:0] POS_FIRST      = 4'd1;

  // low two position bits within a frame: marker, field start, field end
  localparam logic [1:0] SLOT_MARKER = 2'd0;
  localparam logic [1:0] SLOT_START  = 2'd1;

  // characters
  localparam logic [7:0] CHR_A     = 8'h61;
  localparam logic [7:0] CHR_B     = 8'h62;
  localparam logic [7:0] CHR_C     = 8'h63;
  localparam logic [7:0] CHR_S     = 8'h73;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_PLUS  = 8'h2B;
  localparam logic [7:0] CHR_MINUS = 8'h2D;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;

  // command numbers
  localparam logic signed [10:0] CMD_WORK_ON  = 11'sd111;
  localparam logic signed [10:0] CMD_WORK_OFF = 11'sd100;
  localparam logic signed [10:0] CMD_HOME     = 11'sd200;

  // transaction opcodes
  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic KIND_COORD = 1'b0;
  localparam logic KIND_CMD   = 1'b1;

  typedef enum logic [2:0] {
    CLS_WHITE,
    CLS_PLUS,
    CLS_MINUS,
    CLS_DIGIT,
    CLS_OTHER
  } chr_class_e;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_COORD = 2'd1,
    MODE_CMD   = 2'd2
  } frame_mode_e;

  typedef enum logic [1:0] {
    PH_WHITE,
    PH_DIGITS,
    PH_STOP
  } field_phase_e;

  // classified transaction handed from front to back
  typedef struct packed {
    logic       op;
    chr_class_e cls;
    logic [3:0] digit;
    logic       is_a;
    logic       is_b;
    logic       is_c;
    logic       is_s;
  } item_t;

endpackage

/* design/acfp_front.sv */
// front part: accepts transactions, classifies the byte, queues the result
// depends on acfp_pkg
module acfp_front #(
  parameter int unsigned QueueDepth = acfp_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                op_i,
  input  logic [7:0]          rx_byte_i,
  output logic                q_valid_o,
  input  logic                q_ready_i,
  output acfp_pkg::item_t     q_item_o
);
  import acfp_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

  item_t            item;
  item_t            mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push, pop;

  // byte classification
  always_comb begin
    item       = '0;
    item.op    = op_i;
    item.digit = 4'(rx_byte_i - CHR_ZERO);
    item.is_a  = (rx_byte_i == CHR_A);
    item.is_b  = (rx_byte_i == CHR_B);
    item.is_c  = (rx_byte_i == CHR_C);
    item.is_s  = (rx_byte_i == CHR_S);
    if (rx_byte_i == CHR_SPACE || (rx_byte_i >= CHR_TAB && rx_byte_i <= CHR_CR)) begin
      item.cls = CLS_WHITE;
    end else if (rx_byte_i == CHR_PLUS) begin
      item.cls = CLS_PLUS;
    end else if (rx_byte_i == CHR_MINUS) begin
      item.cls = CLS_MINUS;
    end else if (rx_byte_i >= CHR_ZERO && rx_byte_i <= CHR_NINE) begin
      item.cls = CLS_DIGIT;
    end else begin
      item.cls = CLS_OTHER;
    end
  end

  // queue control
  assign in_ready_o = (cnt_q != FullCnt);
  assign q_valid_o  = (cnt_q != '0);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;
  assign q_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

endmodule

/* design/acfp_back.sv */
// back part: frame sequencer, running field parse, flags and result register
// depends on acfp_pkg
module acfp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  output logic                q_ready_o,
  input  acfp_pkg::item_t     q_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                frame_kind_o,
  output logic                format_ok_o,
  output logic                data_valid_o,
  output logic signed [10:0]  angle_value_o,
  output logic signed [10:0]  line_value_o,
  output logic signed [10:0]  command_value_o,
  output logic                work_enabled_o,
  output logic                reset_request_o
);
  import acfp_pkg::*;

  frame_mode_e         mode_q, mode_d;
  logic [3:0]          pos_q, pos_d;
  field_phase_e        ph_q, ph_d;
  logic                neg_q, neg_d;
  logic [9:0]          val_q, val_d;
  logic signed [10:0]  f1_q, f1_d, f2_q, f2_d;
  logic signed [11:0]  f12_q, f12_d;
  logic                mark_b_q, mark_b_d;
  logic                fmt_q, fmt_d;
  logic signed [10:0]  angle_q, angle_d, line_q, line_d;
  logic                work_q, work_d, rst_flag_q, rst_flag_d;

  logic                out_valid_q, out_valid_d;
  logic                kind_q, kind_d, fok_q, fok_d, dv_q, dv_d;
  logic signed [10:0]  ang_o_q, ang_o_d, lin_o_q, lin_o_d, cmd_o_q, cmd_o_d;
  logic                wrk_o_q, wrk_o_d, req_o_q, req_o_d;

  logic                pop;
  logic                emit;
  field_phase_e        st_ph;
  logic                st_neg;
  logic [9:0]          st_val;
  logic [13:0]         mul10;
  logic signed [10:0]  field_val;

  assign q_ready_o = !out_valid_q || out_ready_i;
  assign pop       = q_valid_i && q_ready_o;

  // running atoi step on the current character
  always_comb begin
    if (pos_q[1:0] == SLOT_START) begin
      st_ph  = PH_WHITE;
      st_neg = 1'b0;
      st_val = '0;
    end else begin
      st_ph  = ph_q;
      st_neg = neg_q;
      st_val = val_q;
    end
    mul10 = 14'({st_val, 3'b000}) + 14'({st_val, 1'b0}) + 14'(q_item_i.digit);
    ph_d  = st_ph;
    neg_d = st_neg;
    val_d = st_val;
    case (st_ph)
      PH_WHITE: begin
        case (q_item_i.cls)
          CLS_WHITE: ph_d = PH_WHITE;
          CLS_PLUS:  ph_d = PH_DIGITS;
          CLS_MINUS: begin
            ph_d  = PH_DIGITS;
            neg_d = 1'b1;
          end
          CLS_DIGIT: begin
            ph_d  = PH_DIGITS;
            val_d = mul10[9:0];
          end
          default:   ph_d = PH_STOP;
        endcase
      end
      PH_DIGITS: begin
        if (q_item_i.cls == CLS_DIGIT) begin
          val_d = mul10[9:0];
        end else begin
          ph_d = PH_STOP;
        end
      end
      default: ph_d = PH_STOP;
    endcase
    field_val = neg_d ? -$signed({1'b0, val_d}) : $signed({1'b0, val_d});
  end

  // frame sequencer and result assembly
  always_comb begin
    mode_d      = mode_q;
    pos_d       = pos_q;
    f1_d        = f1_q;
    f2_d        = f2_q;
    f12_d       = f12_q;
    mark_b_d    = mark_b_q;
    fmt_d       = fmt_q;
    angle_d     = angle_q;
    line_d      = line_q;
    work_d      = work_q;
    rst_flag_d  = rst_flag_q;
    emit        = 1'b0;
    kind_d      = kind_q;
    fok_d       = fok_q;
    dv_d        = dv_q;
    ang_o_d     = ang_o_q;
    lin_o_d     = lin_o_q;
    cmd_o_d     = cmd_o_q;
    wrk_o_d     = wrk_o_q;
    req_o_d     = req_o_q;

    if (pop) begin
      if (q_item_i.op == OP_CLEAR) begin
        rst_flag_d = 1'b0;
      end else begin
        unique case (mode_q)
          MODE_COORD: begin
            pos_d = pos_q + 1'b1;
            if (pos_q == POS_MARK_B) begin
              mark_b_d = q_item_i.is_b;
            end else if (pos_q == POS_MARK_C) begin
              fmt_d = mark_b_q && q_item_i.is_c;
              f12_d = {f1_q[10], f1_q} + {f2_q[10], f2_q};
            end else if (pos_q == POS_FIELD1_END) begin
              f1_d = field_val;
            end else if (pos_q == POS_FIELD2_END) begin
              f2_d = field_val;
            end else if (pos_q == POS_COORD_LAST) begin
              emit    = 1'b1;
              mode_d  = MODE_IDLE;
              pos_d   = '0;
              if (fmt_q) begin
                angle_d = f1_q;
                line_d  = f2_q;
              end
              kind_d  = KIND_COORD;
              fok_d   = fmt_q;
              dv_d    = fmt_q && ({field_val[10], field_val} == f12_q);
              ang_o_d = fmt_q ? f1_q : angle_q;
              lin_o_d = fmt_q ? f2_q : line_q;
              cmd_o_d = '0;
              wrk_o_d = work_q;
              req_o_d = rst_flag_q;
            end
          end
          MODE_CMD: begin
            pos_d = pos_q + 1'b1;
            if (pos_q == POS_CMD_LAST) begin
              emit   = 1'b1;
              mode_d = MODE_IDLE;
              pos_d  = '0;
              if (field_val == CMD_WORK_ON) begin
                work_d = 1'b1;
              end else if (field_val == CMD_WORK_OFF) begin
                work_d = 1'b0;
              end else if (field_val == CMD_HOME) begin
                rst_flag_d = 1'b1;
              end
              kind_d  = KIND_CMD;
              fok_d   = 1'b0;
              dv_d    = 1'b0;
              ang_o_d = angle_q;
              lin_o_d = line_q;
              cmd_o_d = field_val;
              wrk_o_d = work_d;
              req_o_d = rst_flag_d;
            end
          end
          default: begin
            mode_d = MODE_IDLE;
            if (q_item_i.is_a) begin
              mode_d = MODE_COORD;
              pos_d  = POS_FIRST;
            end else if (q_item_i.is_s) begin
              mode_d = MODE_CMD;
              pos_d  = POS_FIRST;
            end
          end
        endcase
      end
    end

    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      pos_q       <= '0;
      ph_q        <= PH_WHITE;
      neg_q       <= 1'b0;
      val_q       <= '0;
      angle_q     <= '0;
      line_q      <= '0;
      work_q      <= 1'b0;
      rst_flag_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      pos_q       <= pos_d;
      if (pop && q_item_i.op == OP_BYTE && mode_q != MODE_IDLE) begin
        ph_q  <= ph_d;
        neg_q <= neg_d;
        val_q <= val_d;
      end
      angle_q     <= angle_d;
      line_q      <= line_d;
      work_q      <= work_d;
      rst_flag_q  <= rst_flag_d;
      out_valid_q <= out_valid_d;
    end
  end

  // field holding registers and result payload
  always_ff @(posedge clk_i) begin
    f1_q     <= f1_d;
    f2_q     <= f2_d;
    f12_q    <= f12_d;
    mark_b_q <= mark_b_d;
    fmt_q    <= fmt_d;
    kind_q   <= kind_d;
    fok_q    <= fok_d;
    dv_q     <= dv_d;
    ang_o_q  <= ang_o_d;
    lin_o_q  <= lin_o_d;
    cmd_o_q  <= cmd_o_d;
    wrk_o_q  <= wrk_o_d;
    req_o_q  <= req_o_d;
  end

  assign out_valid_o     = out_valid_q;
  assign frame_kind_o    = kind_q;
  assign format_ok_o     = fok_q;
  assign data_valid_o    = dv_q;
  assign angle_value_o   = ang_o_q;
  assign line_value_o    = lin_o_q;
  assign command_value_o = cmd_o_q;
  assign work_enabled_o  = wrk_o_q;
  assign reset_request_o = req_o_q;

`ifndef SYNTHESIS
  // position stays within the frame of the current mode
  a_pos_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_IDLE |-> pos_q == '0)
    else $error("position nonzero while idle");
  a_pos_coord: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_COORD |-> (pos_q >= POS_FIRST && pos_q <= POS_COORD_LAST))
    else $error("coordinate position out of frame");
  a_pos_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_CMD |-> (pos_q >= POS_FIRST && pos_q <= POS_CMD_LAST))
    else $error("command position out of frame");
  // a valid result implies good format, and command results carry neither
  a_result_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((!dv_q || fok_q) && (kind_q == KIND_COORD || !fok_q)))
    else $error("inconsistent result flags");
  // a pending result is not overwritten while stalled
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(cmd_o_q) && $stable(kind_q))
    else $error("stalled result changed");
`endif

endmodule

/* design/ascii_coordinate_frame_parser_unit.sv */
// top level of the ascii coordinate and command frame parser
// depends on acfp_pkg, acfp_front and acfp_back
//
// Takes one received byte (or a clear-request transaction) per clock cycle and
// returns one result transaction for each completed 12-byte coordinate frame or
// 4-byte command frame; fields are parsed on the fly as bytes arrive, so no
// frame buffer is kept. Sustained rate is one transaction per cycle while the
// result side keeps taking results; after the last byte of its frame, a result
// passes through the front queue and then the result register. The front queue
// depth (QueueDepth, default two) sets how many transactions are absorbed while
// the result side stalls.
module ascii_coordinate_frame_parser_unit #(
  parameter int unsigned QueueDepth = acfp_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                op_i,
  input  logic [7:0]          rx_byte_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                frame_kind_o,
  output logic                format_ok_o,
  output logic                data_valid_o,
  output logic signed [10:0]  angle_value_o,
  output logic signed [10:0]  line_value_o,
  output logic signed [10:0]  command_value_o,
  output logic                work_enabled_o,
  output logic                reset_request_o
);
  import acfp_pkg::*;

  item_t q_item;
  logic  q_valid;
  logic  q_ready;

  // classify and queue
  acfp_front #(
    .QueueDepth(QueueDepth)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .rx_byte_i  (rx_byte_i),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_item_o   (q_item)
  );

  // parse frames and produce results
  acfp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_ready_o       (q_ready),
    .q_item_i        (q_item),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .frame_kind_o    (frame_kind_o),
    .format_ok_o     (format_ok_o),
    .data_valid_o    (data_valid_o),
    .angle_value_o   (angle_value_o),
    .line_value_o    (line_value_o),
    .command_value_o (command_value_o),
    .work_enabled_o  (work_enabled_o),
    .reset_request_o (reset_request_o)
  );

endmodule
